/* design/ddsdc_pkg.sv */
// ----------------------------------------------------------------------------
// ddsdc_pkg
// Shared types and constants for the DDS DX10 header down-converter:
// stream modes, result status codes, header offsets and format codes.
// ----------------------------------------------------------------------------
package ddsdc_pkg;

	// stream mode, one-hot
	typedef enum logic [3:0] {
		MODE_DECIDE  = 4'b0001,
		MODE_PASS    = 4'b0010,
		MODE_CONVERT = 4'b0100,
		MODE_FAIL    = 4'b1000
	} mode_t;

	// result status codes
	localparam logic [2:0] ST_PASS      = 3'd0;
	localparam logic [2:0] ST_CONV      = 3'd1;
	localparam logic [2:0] ST_MALFORMED = 3'd2;
	localparam logic [2:0] ST_RESOURCE  = 3'd3;
	localparam logic [2:0] ST_FORMAT    = 3'd4;

	// header byte offsets
	localparam int unsigned POS_SAT   = 148;
	localparam int unsigned HOLD_BASE = 84;
	localparam int unsigned HOLD_DEPTH = 64;
	localparam int unsigned HOLD_AW   = $clog2(HOLD_DEPTH);
	localparam int unsigned EXT_BASE  = 128;
	localparam int unsigned CAPS2_B1  = 113;

	// held-buffer indexes used by the rewrite
	localparam logic [HOLD_AW-1:0] IDX_FOURCC_0 = HOLD_AW'(0);
	localparam logic [HOLD_AW-1:0] IDX_FOURCC_1 = HOLD_AW'(1);
	localparam logic [HOLD_AW-1:0] IDX_FOURCC_2 = HOLD_AW'(2);
	localparam logic [HOLD_AW-1:0] IDX_FOURCC_3 = HOLD_AW'(3);
	localparam logic [HOLD_AW-1:0] IDX_CAPS2_B1 = HOLD_AW'(CAPS2_B1 - HOLD_BASE);
	localparam logic [HOLD_AW-1:0] IDX_CONV_END = HOLD_AW'(EXT_BASE - HOLD_BASE - 1);

	// magic 'DDS ' and fourCC 'DX10', byte by byte
	localparam logic [7:0] MAGIC_BYTES [4] = '{8'h44, 8'h44, 8'h53, 8'h20};
	localparam logic [7:0] DX10_BYTES  [4] = '{8'h44, 8'h58, 8'h31, 8'h30};
	localparam logic [7:0] CHAR_T      = 8'h54;
	localparam logic [7:0] CHAR_1      = 8'h31;
	localparam logic [7:0] CHAR_3      = 8'h33;
	localparam logic [7:0] CHAR_5      = 8'h35;

	localparam logic [7:0] HDR_SIZE    = 8'd124;
	localparam logic [7:0] PF_SIZE     = 8'd32;
	localparam logic [7:0] DIM_TEX2D   = 8'd3;
	localparam logic [7:0] ARRAY_ONE   = 8'd1;
	localparam logic [31:0] CUBE_FLAG  = 32'h0000_0004;
	localparam logic [7:0] CUBE_CAPS_BYTE1 = 8'hFE;

	// block-compressed format codes
	localparam logic [31:0] FMT_BC1_UNORM = 32'd71;
	localparam logic [31:0] FMT_BC1_SRGB  = 32'd72;
	localparam logic [31:0] FMT_BC2_UNORM = 32'd74;
	localparam logic [31:0] FMT_BC2_SRGB  = 32'd75;
	localparam logic [31:0] FMT_BC3_UNORM = 32'd77;
	localparam logic [31:0] FMT_BC3_SRGB  = 32'd78;

	// legacy fourCC digit for a format, zero when there is no mapping
	function automatic logic [7:0] legacy_digit(input logic [31:0] fmt);
		logic [7:0] d;
		case (fmt) inside
			FMT_BC1_UNORM, FMT_BC1_SRGB: d = CHAR_1;
			FMT_BC2_UNORM, FMT_BC2_SRGB: d = CHAR_3;
			FMT_BC3_UNORM, FMT_BC3_SRGB: d = CHAR_5;
			default:                     d = 8'd0;
		endcase
		return d;
	endfunction

endpackage

/* design/ddsdc_in_if.sv */
// ----------------------------------------------------------------------------
// ddsdc_in_if
// Byte stream channel into the down-converter: one file byte per transaction.
// ----------------------------------------------------------------------------
interface ddsdc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

/* design/ddsdc_out_if.sv */
// ----------------------------------------------------------------------------
// ddsdc_out_if
// Result channel of the down-converter: one file byte or a status per transaction.
// ----------------------------------------------------------------------------
interface ddsdc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_valid;
	logic       out_last;
	logic [2:0] status;

	modport source (output valid, output out_byte, output out_valid, output out_last,
		output status, input ready);
	modport sink   (input valid, input out_byte, input out_valid, input out_last,
		input status, output ready);
endinterface

/* design/ddsdc_ram.sv */
// ----------------------------------------------------------------------------
// ddsdc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ddsdc_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* design/dds_dx10_header_downconvert.sv */
// ----------------------------------------------------------------------------
// dds_dx10_header_downconvert
// Rewrites a DX10-tagged DDS texture header into the legacy fourCC form on a
// byte stream; other files pass unchanged, failures end in a status result.
//
//   channel  dir  handshake      payload
//   din      in   valid/ready    in_byte[7:0], in_last
//   dout     out  valid/ready    out_byte[7:0], out_valid, out_last, status[2:0]
//
// One byte per cycle in steady state while din is not stalled; bytes that are
// not held reach dout in the cycle after they are taken. Bytes 84..147 go into
// a 64-entry held buffer; when the header decision or an early end of file
// releases it, din is stalled for a priming read, then one byte per free dout slot, up to 44 bytes.
// arst_n clears the control state; the held buffer needs no clearing.
// dout backpressure stalls din through the single output register.
// ----------------------------------------------------------------------------
module dds_dx10_header_downconvert (
	input logic        clk,
	input logic        arst_n,
	ddsdc_in_if.sink   din,
	ddsdc_out_if.source dout
);
	import ddsdc_pkg::*;

	// position and header tracking
	logic [7:0]         pos_q;
	mode_t              mode_q, mode_n;
	logic [3:0]         hc_q, hc_n;     // bit0 hdr size, bit1 pf size, bit2 fourCC flag, bit3 magic
	logic               dx10_q, dx10_n;
	logic [31:0]        fmt_q, fmt_n;
	logic [31:0]        misc_q, misc_n;
	logic [1:0]         da_q, da_n;     // bit0 dimension, bit1 array size
	logic [2:0]         code_q;
	logic [7:0]         digit_q;
	logic               cube_q;

	// release burst
	logic               burst_q, primed_q, bconv_q, blast_q;
	logic [HOLD_AW-1:0] idx_q, end_q;

	// output register
	logic               ovalid_q;
	logic [7:0]         obyte_q;
	logic               odata_q, olast_q;
	logic [2:0]         ostat_q;

	logic               acc, bload, oroom;
	logic [7:0]         b, p, off;
	logic [2:0]         code_n;
	logic [7:0]         digit_n;
	logic               emit, e_valid, e_last, start;
	logic [7:0]         e_byte;
	logic [2:0]         e_stat;
	logic [HOLD_AW-1:0] s_end;
	logic               s_conv;
	logic               ram_we;
	logic [HOLD_AW-1:0] raddr;
	logic [7:0]         rdata, bbyte;

	assign b     = din.in_byte;
	assign p     = pos_q;
	assign off   = pos_q - 8'(HOLD_BASE);
	assign oroom = !ovalid_q || dout.ready;
	assign din.ready = !burst_q && oroom;
	assign acc   = din.valid && din.ready;
	assign bload = burst_q && primed_q && oroom;

	// header field tracking on the current byte
	always_comb begin
		hc_n   = hc_q;
		dx10_n = dx10_q;
		fmt_n  = fmt_q;
		misc_n = misc_q;
		da_n   = da_q;
		if (p < 8'd4) begin
			hc_n[3] = (p == 8'd0 || hc_q[3]) && (b == MAGIC_BYTES[p[1:0]]);
		end else if (p < 8'd8) begin
			hc_n[0] = (p == 8'd4) ? (b == HDR_SIZE) : (hc_q[0] && b == 8'd0);
		end else if (p >= 8'd76 && p < 8'd80) begin
			hc_n[1] = (p == 8'd76) ? (b == PF_SIZE) : (hc_q[1] && b == 8'd0);
		end else if (p == 8'd80) begin
			hc_n[2] = b[2];
		end else if (p >= 8'd84 && p < 8'd88) begin
			dx10_n = (p == 8'd84 || dx10_q) && (b == DX10_BYTES[p[1:0]]);
		end else if (p >= 8'd128 && p < 8'd132) begin
			fmt_n[8*p[1:0] +: 8] = fmt_q[8*p[1:0] +: 8] | b;
		end else if (p >= 8'd132 && p < 8'd136) begin
			da_n[0] = (p == 8'd132) ? (b == DIM_TEX2D) : (da_q[0] && b == 8'd0);
		end else if (p >= 8'd136 && p < 8'd140) begin
			misc_n[8*p[1:0] +: 8] = misc_q[8*p[1:0] +: 8] | b;
		end else if (p >= 8'd140 && p < 8'd144) begin
			da_n[1] = (p == 8'd140) ? (b == ARRAY_ONE) : (da_q[1] && b == 8'd0);
		end
	end

	// classification: malformed, then resource, then format
	always_comb begin
		digit_n = legacy_digit(fmt_n);
		if (hc_n != 4'hF) begin
			code_n = ST_MALFORMED;
		end else if (da_n != 2'b11 || (misc_n & ~CUBE_FLAG) != 32'd0) begin
			code_n = ST_RESOURCE;
		end else if (digit_n == 8'd0) begin
			code_n = ST_FORMAT;
		end else begin
			code_n = ST_CONV;
		end
	end

	// per-byte decision
	always_comb begin
		mode_n  = mode_q;
		emit    = 1'b0;
		e_byte  = b;
		e_valid = 1'b1;
		e_last  = din.in_last;
		e_stat  = ST_PASS;
		start   = 1'b0;
		s_end   = '0;
		s_conv  = 1'b0;
		unique case (mode_q)
			MODE_DECIDE: begin
				if (p == 8'd3 && !hc_n[3]) begin
					mode_n = MODE_PASS;
					emit   = 1'b1;
				end else if (p == 8'd87 && (!hc_n[3] || !dx10_n)) begin
					mode_n = MODE_PASS;
					start  = 1'b1;
					s_end  = IDX_FOURCC_3;
				end else if (p < 8'(HOLD_BASE)) begin
					emit = 1'b1;
				end else if (p == 8'(POS_SAT - 1)) begin
					if (code_n == ST_CONV) begin
						mode_n = MODE_CONVERT;
						start  = 1'b1;
						s_end  = IDX_CONV_END;
						s_conv = 1'b1;
					end else begin
						mode_n  = MODE_FAIL;
						emit    = din.in_last;
						e_byte  = 8'd0;
						e_valid = 1'b0;
						e_stat  = code_n;
					end
				end else if (din.in_last) begin
					if (p < 8'(EXT_BASE - 1)) begin
						start = 1'b1;
						s_end = off[HOLD_AW-1:0];
					end else begin
						emit    = 1'b1;
						e_byte  = 8'd0;
						e_valid = 1'b0;
						e_stat  = ST_MALFORMED;
					end
				end
			end
			MODE_PASS: begin
				emit = 1'b1;
			end
			MODE_CONVERT: begin
				emit   = 1'b1;
				e_stat = ST_CONV;
			end
			MODE_FAIL: begin
				emit    = din.in_last;
				e_byte  = 8'd0;
				e_valid = 1'b0;
				e_stat  = code_q;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// tracking state; everything returns to reset after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			mode_q <= MODE_DECIDE;
			hc_q   <= '0;
			dx10_q <= 1'b0;
			fmt_q  <= '0;
			misc_q <= '0;
			da_q   <= '0;
			code_q <= ST_PASS;
		end else if (acc) begin
			if (din.in_last) begin
				pos_q  <= '0;
				mode_q <= MODE_DECIDE;
				hc_q   <= '0;
				dx10_q <= 1'b0;
				fmt_q  <= '0;
				misc_q <= '0;
				da_q   <= '0;
				code_q <= ST_PASS;
			end else begin
				if (pos_q != 8'(POS_SAT)) begin
					pos_q <= pos_q + 8'd1;
				end
				mode_q <= mode_n;
				hc_q   <= hc_n;
				dx10_q <= dx10_n;
				fmt_q  <= fmt_n;
				misc_q <= misc_n;
				da_q   <= da_n;
				if (mode_q == MODE_DECIDE && p == 8'(POS_SAT - 1)) begin
					code_q <= code_n;
				end
			end
		end
	end

	// rewrite values captured at the decision
	always_ff @(posedge clk) begin
		if (acc && start && s_conv) begin
			digit_q <= digit_n;
			cube_q  <= misc_n[2];
		end
	end

	// held buffer for offsets 84..147
	assign ram_we = acc && mode_q == MODE_DECIDE && p >= 8'(HOLD_BASE) && p < 8'(POS_SAT);
	assign raddr  = (bload && idx_q != end_q) ? idx_q + HOLD_AW'(1) : idx_q;

	ddsdc_ram #(
		.WIDTH (8),
		.DEPTH (HOLD_DEPTH)
	) u_hold (
		.clk   (clk),
		.we    (ram_we),
		.waddr (off[HOLD_AW-1:0]),
		.wdata (b),
		.raddr (raddr),
		.rdata (rdata)
	);

	// release burst control: a priming read, then one byte per free output slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burst_q  <= 1'b0;
			primed_q <= 1'b0;
			idx_q    <= '0;
			end_q    <= '0;
			bconv_q  <= 1'b0;
			blast_q  <= 1'b0;
		end else if (acc && start) begin
			burst_q  <= 1'b1;
			primed_q <= 1'b0;
			idx_q    <= '0;
			end_q    <= s_end;
			bconv_q  <= s_conv;
			blast_q  <= din.in_last;
		end else if (burst_q) begin
			primed_q <= 1'b1;
			if (bload) begin
				if (idx_q == end_q) begin
					burst_q <= 1'b0;
				end else begin
					idx_q <= idx_q + HOLD_AW'(1);
				end
			end
		end
	end

	// legacy header rewrite of released bytes
	always_comb begin
		bbyte = rdata;
		if (bconv_q) begin
			case (idx_q)
				IDX_FOURCC_0: bbyte = DX10_BYTES[0];
				IDX_FOURCC_1: bbyte = DX10_BYTES[1];
				IDX_FOURCC_2: bbyte = CHAR_T;
				IDX_FOURCC_3: bbyte = digit_q;
				IDX_CAPS2_B1: bbyte = cube_q ? (rdata | CUBE_CAPS_BYTE1) : rdata;
				default:      bbyte = rdata;
			endcase
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if ((acc && emit) || bload) begin
			ovalid_q <= 1'b1;
		end else if (dout.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (acc && emit) begin
			obyte_q <= e_byte;
			odata_q <= e_valid;
			olast_q <= e_last;
			ostat_q <= e_last ? e_stat : ST_PASS;
		end else if (bload) begin
			obyte_q <= bbyte;
			odata_q <= 1'b1;
			olast_q <= blast_q && idx_q == end_q;
			ostat_q <= (blast_q && idx_q == end_q && bconv_q) ? ST_CONV : ST_PASS;
		end
	end

	assign dout.valid     = ovalid_q;
	assign dout.out_byte  = obyte_q;
	assign dout.out_valid = odata_q;
	assign dout.out_last  = olast_q;
	assign dout.status    = ostat_q;

	// a status-only result always closes the file
	a_status_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid && !dout.out_valid |-> dout.out_last)
		else $error("status-only result without out_last");

	// burst index never runs past its end
	a_burst_idx: assert property (@(posedge clk) disable iff (!arst_n)
		burst_q |-> idx_q <= end_q)
		else $error("release index beyond end");

	// a burst start raises burst_q and drops din.ready
	a_burst_block: assert property (@(posedge clk) disable iff (!arst_n)
		acc && start |=> !din.ready && burst_q)
		else $error("input accepted during release");

endmodule
